// ===== hw/rtl/ssi_pkg.sv =====
// Shared types and codes for the sorted set insert block.
`timescale 1ns / 1ps
`default_nettype none

package ssi_pkg;

    // result status codes
    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_DUPLICATE = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // width of the position and count result fields
    localparam int unsigned FIELD_W = 7;

    // compare flags one cell reports about its stored key versus the new key
    typedef struct packed {
        logic lt;   // occupied and stored key below the new key
        logic eq;   // occupied and stored key equal to the new key
    } ssi_cmp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sorted_set_insert_top.sv =====
// Sorted set insert: top level with the cell chain, fill count and result register.
//
// Keeps an ascending set of unique keys in a chain of DEPTH cells.
// Input channel: key, start_new with in_valid / in_stall. Output channel:
// status, position, count with out_valid / out_stall. A transfer happens on
// a rising edge where valid is high and stall is low.
// Every cell compares its key with the incoming key in the same cycle; the
// chain shifts larger keys up one cell and drops the new key into place at
// the accepting edge. The result is registered, and one key is taken every
// cycle while in_stall is low, set by the single compare-and-shift pass
// through the chain and the position encoder behind it.
// start_new empties the set before its key is handled.
// When the receiver stalls with a result pending, in_stall is raised and
// no new key is taken until the result transfers.
// Reset clears the fill count and the output valid; the cell contents are
// not cleared since slots at or above the count are never looked at.
`timescale 1ns / 1ps
`default_nettype none

module sorted_set_insert_top
    import ssi_pkg::*;
#(
    parameter int unsigned DEPTH     = 64,
    parameter int unsigned KEY_WIDTH = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [15:0]        key,
    input  wire logic               start_new,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              status,
    output logic [FIELD_W-1:0]      position,
    output logic [FIELD_W-1:0]      count
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [KEY_WIDTH-1:0] new_key;
    logic                 accept;
    logic [CNT_W-1:0]     fill_count_reg;
    logic [CNT_W-1:0]     fill_count_next;
    logic [CNT_W-1:0]     eff_count;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [1:0]           status_reg;
    logic [1:0]           status_next;
    logic [FIELD_W-1:0]   position_reg;
    logic [FIELD_W-1:0]   position_next;
    logic [FIELD_W-1:0]   count_reg;
    logic [FIELD_W-1:0]   count_next;
    logic                 any_eq;
    logic                 is_full;
    logic                 do_insert;
    logic [CNT_W-1:0]     ins_pos;

    ssi_cmp_t             cmp      [DEPTH];
    logic [KEY_WIDTH-1:0] entry    [DEPTH];
    logic                 prev_lt  [DEPTH];
    logic [KEY_WIDTH-1:0] prev_ent [DEPTH];
    logic [DEPTH-1:0]     occ;
    logic [DEPTH-1:0]     first_ge;

    assign new_key   = KEY_WIDTH'(key);
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign eff_count = start_new ? '0 : fill_count_reg;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            assign occ[gi] = (CNT_W'(gi) < eff_count);
            if (gi == 0)
            begin : g_first
                assign prev_lt[gi]  = 1'b1;
                assign prev_ent[gi] = new_key;
            end
            else
            begin : g_rest
                assign prev_lt[gi]  = cmp[gi-1].lt;
                assign prev_ent[gi] = entry[gi-1];
            end
            assign first_ge[gi] = prev_lt[gi] && !cmp[gi].lt;

            ssi_cell #(
                .KEY_WIDTH (KEY_WIDTH)
            ) u_cell (
                .clk        (clk),
                .new_key    (new_key),
                .occupied   (occ[gi]),
                .load       (do_insert),
                .prev_lt    (prev_lt[gi]),
                .prev_entry (prev_ent[gi]),
                .cmp        (cmp[gi]),
                .entry      (entry[gi])
            );
        end
    endgenerate

    // lt flags form a thermometer, so at most one cell sees the boundary
    always_comb
    begin
        any_eq  = 1'b0;
        ins_pos = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            any_eq = any_eq | cmp[i].eq;
            if (first_ge[i])
                ins_pos = ins_pos | CNT_W'(i);
        end
    end

    assign is_full   = (eff_count == CNT_W'(DEPTH));
    assign do_insert = accept && !any_eq && !is_full;

    always_comb
    begin
        fill_count_next = fill_count_reg;
        status_next     = status_reg;
        position_next   = position_reg;
        count_next      = count_reg;
        if (accept)
        begin
            if (any_eq)
            begin
                status_next     = ST_DUPLICATE;
                position_next   = '0;
                fill_count_next = eff_count;
            end
            else if (is_full)
            begin
                status_next     = ST_FULL;
                position_next   = '0;
                fill_count_next = eff_count;
            end
            else
            begin
                status_next     = ST_INSERTED;
                position_next   = FIELD_W'(ins_pos);
                fill_count_next = eff_count + CNT_W'(1);
            end
            count_next = FIELD_W'(fill_count_next);
        end
    end

    always_comb
    begin
        if (accept)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        position_reg <= position_next;
        count_reg    <= count_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign position  = position_reg;
    assign count     = count_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ssi_cell.sv =====
// One slot of the sorted chain: compare, hold, or take the key or the lower neighbor's entry.
`timescale 1ns / 1ps
`default_nettype none

module ssi_cell
    import ssi_pkg::*;
#(
    parameter int unsigned KEY_WIDTH = 16
) (
    input  wire logic                 clk,
    input  wire logic [KEY_WIDTH-1:0] new_key,
    input  wire logic                 occupied,
    input  wire logic                 load,
    input  wire logic                 prev_lt,
    input  wire logic [KEY_WIDTH-1:0] prev_entry,
    output ssi_cmp_t                  cmp,
    output logic      [KEY_WIDTH-1:0] entry
);

    logic [KEY_WIDTH-1:0] entry_reg;
    logic [KEY_WIDTH-1:0] entry_next;

    assign cmp.lt = occupied && (entry_reg < new_key);
    assign cmp.eq = occupied && (entry_reg == new_key);
    assign entry  = entry_reg;

    // keys below the new one stay, the slot at the ordered position takes
    // the key, everything above moves up one place
    always_comb
    begin
        if (cmp.lt)
            entry_next = entry_reg;
        else if (prev_lt)
            entry_next = new_key;
        else
            entry_next = prev_entry;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ssi_checker.sv =====
// Port-level checks for the sorted set insert block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ssi_checker
    import ssi_pkg::*;
#(
    parameter int unsigned DEPTH = 64
) (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic [1:0]         status,
    input wire logic [FIELD_W-1:0] position,
    input wire logic [FIELD_W-1:0] count
);

    localparam logic [FIELD_W-1:0] FULL_COUNT = FIELD_W'(DEPTH);

    // a rejected key never reports a position
    a_reject_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_DUPLICATE || status == ST_FULL) |-> position == '0)
        else $error("rejected key with nonzero position");

    // a full rejection only happens with the store at capacity
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> count == FULL_COUNT)
        else $error("full status with count below capacity");

    // an accepted key is followed by a valid result in the next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("no result after accepted key");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(position)
            && $stable(count))
        else $error("stalled result changed");

endmodule

bind sorted_set_insert_top ssi_checker #(
    .DEPTH (DEPTH)
) u_ssi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .position  (position),
    .count     (count)
);

`default_nettype wire

// ===== test/sorted_set_insert_top_tb.sv =====
// Self-checking testbench for the sorted set insert block.
`timescale 1ns / 1ps

module sorted_set_insert_top_tb;
    import ssi_pkg::*;

    localparam int unsigned SET_DEPTH   = 64;
    localparam int unsigned KEY_BITS    = 16;
    localparam int unsigned RAND_ITEMS  = 500;
    localparam int unsigned HOLD_CYCLES = 200;
    localparam int unsigned SETTLE      = 4;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct packed {
        logic [1:0]         status;
        logic [FIELD_W-1:0] position;
        logic [FIELD_W-1:0] count;
    } insert_result_t;

    // Mirror of the set plus the queue of results still owed by the block.
    class insert_scoreboard;
        logic [KEY_BITS-1:0] set_keys [SET_DEPTH];
        int unsigned         fill;
        insert_result_t      owed_q [$];
        int unsigned         errors;
        int unsigned         n_inserted;
        int unsigned         n_duplicate;
        int unsigned         n_full;

        function void flag(string what, int unsigned exp_v, int unsigned act_v);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d",
                         $realtime, what, exp_v, act_v);
        endfunction

        function int unsigned pending();
            return owed_q.size();
        endfunction

        function void note_input(logic [KEY_BITS-1:0] k, logic sn);
            insert_result_t r;
            int unsigned    slot;
            int unsigned    j;
            if (sn)
                fill = 0;
            slot = 0;
            while (slot < fill && set_keys[slot] < k)
                slot++;
            r.position = '0;
            // duplicate check wins over the full check
            if (slot < fill && set_keys[slot] == k)
            begin
                r.status = ST_DUPLICATE;
                n_duplicate++;
            end
            else if (fill >= SET_DEPTH)
            begin
                r.status = ST_FULL;
                n_full++;
            end
            else
            begin
                for (j = fill; j > slot; j--)
                    set_keys[j] = set_keys[j-1];
                set_keys[slot] = k;
                fill++;
                r.status   = ST_INSERTED;
                r.position = slot[FIELD_W-1:0];
                n_inserted++;
            end
            r.count = fill[FIELD_W-1:0];
            owed_q.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic [FIELD_W-1:0] pos,
                                   logic [FIELD_W-1:0] cnt);
            insert_result_t e;
            if (owed_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result: status %0d position %0d count %0d",
                             $realtime, st, pos, cnt);
                return;
            end
            e = owed_q.pop_front();
            if (st !== e.status)
                flag("status", e.status, st);
            if (pos !== e.position)
                flag("position", e.position, pos);
            if (cnt !== e.count)
                flag("count", e.count, cnt);
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [15:0]         key;
    logic                start_new;
    logic                out_valid;
    logic                out_stall;
    logic [1:0]          status;
    logic [FIELD_W-1:0]  position;
    logic [FIELD_W-1:0]  count;

    insert_scoreboard    sb;
    bit                  no_idle;
    bit                  hold_req;
    int unsigned         items_sent;
    int unsigned         cycles;

    sorted_set_insert_top #(
        .DEPTH     (SET_DEPTH),
        .KEY_WIDTH (KEY_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .key       (key),
        .start_new (start_new),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .position  (position),
        .count     (count)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycles, sb.pending());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int unsigned draw_wait();
        return no_idle ? 0 : $urandom_range(0, 19);
    endfunction

    // Offer one key; returns at the falling edge after the transfer.
    task automatic send_item(input logic [KEY_BITS-1:0] k, input logic sn);
        int unsigned gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        key       <= k;
        start_new <= sn;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(k, sn);
        items_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every owed result has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
    endtask

    // Result side
    initial
    begin
        int unsigned gap;
        bit          hold_done;
        hold_done = 1'b0;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            gap = draw_wait();
            if (hold_req && !hold_done)
            begin
                // long hold-off so the block backs up and stalls its input
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            sb.check_result(status, position, count);
            @(negedge clk);
        end
    end

    initial
    begin
        logic [KEY_BITS-1:0] seq_keys [$];
        logic [KEY_BITS-1:0] base;
        logic [KEY_BITS-1:0] k;
        logic                sn;
        int unsigned         seq_idx;
        int unsigned         kind;
        int unsigned         len;
        int unsigned         i;
        int unsigned         rand_goal;

        sb         = new();
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        key        = '0;
        start_new  = 1'b0;
        no_idle    = 1'b0;
        hold_req   = 1'b0;
        items_sent = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // first key after reset, no start_new
        send_item(16'h1234, 1'b0);
        send_item(16'h0000, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'h0000, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'h8000, 1'b0);
        send_item(16'h7FFF, 1'b0);
        send_item(16'h5555, 1'b0);
        send_item(16'hAAAA, 1'b0);
        send_item(16'h8000, 1'b0);
        // new set, then new set again with the same key
        send_item(16'hFFFF, 1'b1);
        send_item(16'h0000, 1'b0);
        send_item(16'hFFFF, 1'b1);
        send_item(16'hFFFF, 1'b1);
        send_item(16'h0001, 1'b0);
        send_item(16'hFFFE, 1'b0);

        rand_goal = items_sent + RAND_ITEMS;
        seq_idx   = 0;
        while (items_sent < rand_goal)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            if (seq_idx == 3)
                hold_req = 1'b1;
            // keep offering keys while the receiver holds off
            if (seq_idx == 6 || (seq_idx != 3 && $urandom_range(0, 9) == 0))
                wait_drained();
            // kinds: 0-1 fill past full, 2-6 narrow window, 7-8 wide, 9 noise
            kind = (seq_idx == 0) ? 0 : $urandom_range(0, 9);
            base = KEY_BITS'($urandom_range(0, 16'hFFFF));
            seq_keys.delete();
            if (kind <= 1)
                len = SET_DEPTH + $urandom_range(4, 20);
            else if (kind <= 6)
                len = $urandom_range(1, 24);
            else
                len = $urandom_range(1, 40);
            for (i = 0; i < len; i++)
            begin
                sn = (i == 0);
                if (kind <= 1 || kind == 7 || kind == 8)
                begin
                    // repeats get likelier once SET_DEPTH keys have been offered
                    if (seq_keys.size() != 0 &&
                        $urandom_range(0, (i >= SET_DEPTH) ? 1 : 7) == 0)
                        k = seq_keys[$urandom_range(0, seq_keys.size() - 1)];
                    else
                        k = KEY_BITS'($urandom_range(0, 16'hFFFF));
                end
                else if (kind <= 6)
                begin
                    k = base + KEY_BITS'($urandom_range(0, 31));
                end
                else
                begin
                    sn = ($urandom_range(0, 5) == 0);
                    case ($urandom_range(0, 3))
                        0:       k = '0;
                        1:       k = '1;
                        default: k = base ^ KEY_BITS'($urandom_range(0, 15));
                    endcase
                end
                seq_keys.push_back(k);
                send_item(k, sn);
            end
            seq_idx++;
        end

        wait_drained();
        repeat (SETTLE) @(negedge clk);

        $display("Covered %0d keys in %0d random sequences plus directed cases",
                 items_sent, seq_idx);
        $display("Outcomes: %0d inserted, %0d duplicates, %0d rejected on a full set, %0d errors",
                 sb.n_inserted, sb.n_duplicate, sb.n_full, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
